### rtl/p3a_pkg.sv
// Shared types and constants for the 3D pitot airspeed block.
package p3a_pkg;

	localparam int unsigned PresW = 22;
	localparam int unsigned TimeW = 32;
	localparam int unsigned GainW = 16;
	localparam int unsigned RhoW = 12;
	localparam int unsigned FwdW = 20;
	localparam int unsigned SideW = 21;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDataW = 16;

	// Numerator of 20000000*p: 25 bits of scale times 21 bits of p.
	localparam int unsigned NumW = 46;
	// Width of the square root result; the root of NumW bits needs at most NumW/2 bits.
	localparam int unsigned SqW = 24;
	// Side speed numerator: vx (24) * gain (16s) * p_angle (22s).
	localparam int unsigned SnW = 62;

	localparam logic [24:0] SpeedScale = 25'd20000000;

	localparam logic [FwdW-1:0] FwdMax = '1;
	localparam logic signed [SideW-1:0] SideMax = 21'sd1048575;
	localparam logic signed [SideW-1:0] SideMin = -21'sd1048576;

	typedef enum logic [1:0] {
		REQ_DYN = 2'd0,
		REQ_AOA = 2'd1,
		REQ_AOS = 2'd2,
		REQ_NONE = 2'd3
	} req_t;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_GAIN_AOA = 3'd0,
		CFG_GAIN_AOS = 3'd1,
		CFG_RHO = 3'd2,
		CFG_MIN_P = 3'd3,
		CFG_WINDOW = 3'd4
	} cfg_idx_t;

	// Serial divider: unsigned num / den, one quotient bit per cycle.
	typedef struct packed {
		logic start;
		logic [SnW-1:0] num;
		logic [SnW-1:0] den;
	} div_req_t;

endpackage

### rtl/p3a_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module p3a_div
	import p3a_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input div_req_t req,
	output logic done,
	output logic [SnW-1:0] quot,
	output logic [SnW-1:0] rem
);

	logic [SnW-1:0] q_q;
	logic [SnW-1:0] r_q;
	logic [SnW-1:0] d_q;
	logic [6:0] cnt_q;
	logic busy_q;
	logic [SnW:0] trial;

	assign trial = {r_q, q_q[SnW-1]} - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 7'(SnW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			q_q <= req.num;
			r_q <= '0;
			d_q <= req.den;
		end else if (busy_q) begin
			if (!trial[SnW]) begin
				r_q <= trial[SnW-1:0];
				q_q <= {q_q[SnW-2:0], 1'b1};
			end else begin
				r_q <= {r_q[SnW-2:0], q_q[SnW-1]};
				q_q <= {q_q[SnW-2:0], 1'b0};
			end
		end
	end

	assign quot = q_q;
	assign rem = r_q;

endmodule

### rtl/p3a_sqrt.sv
// Digit-serial integer square root, two radicand bits per cycle.
module p3a_sqrt
	import p3a_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [NumW-1:0] radicand,
	output logic done,
	output logic [SqW-1:0] root
);

	logic [NumW-1:0] x_q;
	logic [SqW+1:0] r_q;
	logic [SqW-1:0] y_q;
	logic [4:0] cnt_q;
	logic busy_q;
	logic [SqW+1:0] rs;
	logic [SqW+2:0] tr;

	assign rs = {r_q[SqW-1:0], x_q[NumW-1 -: 2]};
	assign tr = {1'b0, rs} - {1'b0, y_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 5'(NumW / 2);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= radicand;
			r_q <= '0;
			y_q <= '0;
		end else if (busy_q) begin
			x_q <= {x_q[NumW-3:0], 2'b00};
			if (!tr[SqW+2]) begin
				r_q <= tr[SqW+1:0];
				y_q <= {y_q[SqW-2:0], 1'b1};
			end else begin
				r_q <= rs;
				y_q <= {y_q[SqW-2:0], 1'b0};
			end
		end
	end

	assign root = y_q;

endmodule

### rtl/pitot_3d_airspeed_top.sv
// Top level of the 3D pitot airspeed block.
// Angle samples (tuser 1 or 2) are stored and give no item out.
// A dynamic sample gives one item. When it is fresh and above the threshold, the
// item is made by three 62-step runs of the shared serial divider (the radicand
// and the two side quotients), the 23-step serial square root and the 22-step
// shift-add products. A fresh sample at or below the threshold uses only the
// radicand division and the square root. A stale or nonpositive sample passes
// only through the ST_DONE and ST_OUT states. One sample is worked on at a time.
// The output register lets the next sample in while a result waits.
module pitot_3d_airspeed_top
	import p3a_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [55:0] s_tdata, // in_pressure[21:0], in_time_ms[53:22]
	input logic [1:0] s_tuser, // req_type
	output logic m_tvalid,
	input logic m_tready,
	output logic [95:0] m_tdata, // speed_fwd[19:0], speed_lat[40:20],
	                             // speed_vert[61:41], out_time_ms[93:62]
	output logic m_tuser, // status
	input logic cfg_we,
	input logic [CfgIdxW-1:0] cfg_index,
	input logic [CfgDataW-1:0] cfg_data
);

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_RAD = 9'b000000010,
		ST_SQRT = 9'b000000100,
		ST_MUL = 9'b000001000,
		ST_DIVZ = 9'b000010000,
		ST_DIVY = 9'b000100000,
		ST_DONE = 9'b001000000,
		ST_OUT = 9'b010000000,
		ST_MULW = 9'b100000000
	} state_t;

	state_t state_q;
	logic signed [GainW-1:0] gain_aoa_q, gain_aos_q;
	logic [RhoW-1:0] rho_q;
	logic [15:0] min_p_q, window_q;
	logic signed [PresW-1:0] aoa_p_q, aos_p_q;
	logic [TimeW-1:0] aoa_t_q, aos_t_q;
	logic signed [PresW-1:0] p_q;
	logic [TimeW-1:0] t_q;
	logic [SqW-1:0] vx_q;
	logic signed [SideW-1:0] vz_q, vy_q;
	logic side_q;
	logic stat_q;
	logic out_full_q;
	logic [95:0] out_data_q;
	logic out_stat_q;
	logic [SnW-1:0] numz_q, numy_q, den_q;
	logic [SnW-1:0] mz_q, my_q;
	logic [PresW-1:0] az_q, ay_q;
	logic [4:0] mcnt_q;
	logic negz_q, negy_q;
	div_req_t dreq;
	logic ddone;
	logic [SnW-1:0] dq, dr;
	logic sq_start, sq_done;
	logic [SqW-1:0] root;
	logic [NumW-1:0] rad;
	logic [PresW-1:0] s_p;
	logic [TimeW-1:0] s_t;
	logic [TimeW-1:0] da, ds;
	logic fresh;
	logic signed [SqW+GainW:0] vg_z, vg_y;
	logic [SnW-1:0] qadj;

	assign s_p = s_tdata[21:0];
	assign s_t = s_tdata[53:22];
	assign s_tready = (state_q == ST_IDLE);
	assign da = (s_t >= aoa_t_q) ? s_t - aoa_t_q : aoa_t_q - s_t;
	assign ds = (s_t >= aos_t_q) ? s_t - aos_t_q : aos_t_q - s_t;
	assign fresh = (da < {16'd0, window_q}) && (ds < {16'd0, window_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_aoa_q <= 16'sd4096;
			gain_aos_q <= 16'sd4096;
			rho_q <= 12'd1225;
			min_p_q <= 16'd10;
			window_q <= 16'd100;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_GAIN_AOA: gain_aoa_q <= cfg_data;
				CFG_GAIN_AOS: gain_aos_q <= cfg_data;
				CFG_RHO: rho_q <= cfg_data[RhoW-1:0];
				CFG_MIN_P: min_p_q <= cfg_data;
				CFG_WINDOW: window_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Radicand of the square root is the divider quotient.
	assign rad = dq[NumW-1:0];
	assign sq_start = (state_q == ST_RAD) && ddone;

	// vx*gain in one step; the angle pressure is then shifted in bit by bit
	assign vg_z = $signed({1'b0, vx_q}) * gain_aoa_q;
	assign vg_y = $signed({1'b0, vx_q}) * gain_aos_q;

	// Floor for negative quotients: add one to magnitude when remainder set.
	assign qadj = dq + {{(SnW-1){1'b0}}, (dr != '0)};

	function automatic logic signed [SideW-1:0] sat_side(
		input logic neg,
		input logic [SnW-1:0] q
	);
		logic signed [SideW-1:0] r;
		if (!neg) begin
			r = (q > {{(SnW-SideW){1'b0}}, SideMax}) ? SideMax : SideW'(q);
		end else begin
			r = (q > 62'd1048576) ? SideMin : -$signed(SideW'(q));
		end
		return r;
	endfunction

	always_comb begin
		dreq = '0;
		if (state_q == ST_IDLE && s_tvalid && s_tready &&
				req_t'(s_tuser) == REQ_DYN && fresh && !s_p[PresW-1] && s_p != '0) begin
			dreq.start = 1'b1;
			dreq.num = SnW'({1'b0, s_p[PresW-2:0]} * SpeedScale);
			dreq.den = SnW'((rho_q == '0) ? 12'd1 : rho_q);
		end else if (state_q == ST_MULW && mcnt_q == '0) begin
			dreq.start = 1'b1;
			dreq.num = numz_q;
			dreq.den = den_q;
		end else if (state_q == ST_DIVZ && ddone) begin
			dreq.start = 1'b1;
			dreq.num = numy_q;
			dreq.den = den_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_full_q <= 1'b0;
			aoa_p_q <= '0;
			aos_p_q <= '0;
			aoa_t_q <= '0;
			aos_t_q <= '0;
		end else begin
			if (m_tvalid && m_tready) out_full_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid && s_tready) begin
						p_q <= s_p;
						t_q <= s_t;
						priority case (req_t'(s_tuser))
							REQ_AOA: begin
								aoa_p_q <= s_p;
								aoa_t_q <= s_t;
							end
							REQ_AOS: begin
								aos_p_q <= s_p;
								aos_t_q <= s_t;
							end
							REQ_DYN: begin
								vx_q <= '0;
								vz_q <= '0;
								vy_q <= '0;
								side_q <= $signed(s_p) > $signed({6'd0, min_p_q});
								stat_q <= !fresh;
								if (fresh && !s_p[PresW-1] && s_p != '0) state_q <= ST_RAD;
								else state_q <= ST_DONE;
							end
							default: ;
						endcase
					end
				end
				ST_RAD: if (ddone) state_q <= ST_SQRT;
				ST_SQRT: begin
					if (sq_done) begin
						vx_q <= root;
						state_q <= side_q ? ST_MUL : ST_DONE;
					end
				end
				ST_MUL: begin
					mz_q <= SnW'(vg_z[SqW+GainW] ? -vg_z : vg_z);
					my_q <= SnW'(vg_y[SqW+GainW] ? -vg_y : vg_y);
					az_q <= aoa_p_q[PresW-1] ? PresW'(-aoa_p_q) : aoa_p_q;
					ay_q <= aos_p_q[PresW-1] ? PresW'(-aos_p_q) : aos_p_q;
					negz_q <= vg_z[SqW+GainW] ^ aoa_p_q[PresW-1];
					negy_q <= vg_y[SqW+GainW] ^ aos_p_q[PresW-1];
					numz_q <= '0;
					numy_q <= '0;
					mcnt_q <= 5'(PresW);
					den_q <= SnW'({p_q[PresW-2:0], 12'd0});
					state_q <= ST_MULW;
				end
				// shift-add of the magnitudes, one pressure bit per cycle
				ST_MULW: begin
					if (mcnt_q != '0) begin
						if (az_q[0]) numz_q <= numz_q + mz_q;
						if (ay_q[0]) numy_q <= numy_q + my_q;
						mz_q <= {mz_q[SnW-2:0], 1'b0};
						my_q <= {my_q[SnW-2:0], 1'b0};
						az_q <= {1'b0, az_q[PresW-1:1]};
						ay_q <= {1'b0, ay_q[PresW-1:1]};
						mcnt_q <= mcnt_q - 5'd1;
					end else begin
						state_q <= ST_DIVZ;
					end
				end
				ST_DIVZ: begin
					if (ddone) begin
						vz_q <= sat_side(negz_q, negz_q ? qadj : dq);
						state_q <= ST_DIVY;
					end
				end
				ST_DIVY: begin
					if (ddone) begin
						vy_q <= sat_side(negy_q, negy_q ? qadj : dq);
						state_q <= ST_DONE;
					end
				end
				ST_DONE: state_q <= ST_OUT;
				ST_OUT: begin
					if (!out_full_q) begin
						out_full_q <= 1'b1;
						out_stat_q <= stat_q;
						out_data_q <= {2'b00, t_q, vz_q, vy_q,
							(vx_q > SqW'(FwdMax)) ? FwdMax : vx_q[FwdW-1:0]};
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	p3a_div u_div (
		.clk(clk), .arst_n(arst_n), .req(dreq),
		.done(ddone), .quot(dq), .rem(dr)
	);

	p3a_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start),
		.radicand(rad), .done(sq_done), .root(root)
	);

	assign m_tvalid = out_full_q;
	assign m_tdata = out_data_q;
	assign m_tuser = out_stat_q;

endmodule
